FILE: design/wrm_pkg.sv
// ----------------------------------------------------------------------------
// wrm_pkg: shared definitions for the windowed event rate meter
// Field widths, count limit, reset window length and sequencer states.
// ----------------------------------------------------------------------------
package wrm_pkg;

	localparam int TIME_W = 48;
	localparam int CNT_W  = 32;
	localparam int WIN_W  = 16;
	localparam int STEP_W = $clog2(TIME_W);

	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(500);
	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_DIV,
		ST_CLOSE,
		ST_E1,
		ST_E2,
		ST_E3
	} state_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
	endfunction

endpackage

FILE: design/wrm_div.sv
// ----------------------------------------------------------------------------
// wrm_div: iterative restoring divider
// Divides a time difference by the window length, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module wrm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wrm_pkg::TIME_W-1:0]   dividend,
	input  logic [wrm_pkg::WIN_W-1:0]    divisor,
	output logic                         done,
	output logic [wrm_pkg::TIME_W-1:0]   quot,
	output logic [wrm_pkg::WIN_W-1:0]    rem
);

	logic                          busy_q;
	logic                          done_q;
	logic [wrm_pkg::STEP_W-1:0]    step_q;
	logic [wrm_pkg::WIN_W-1:0]     div_q;
	logic [wrm_pkg::WIN_W-1:0]     rem_q;
	logic [wrm_pkg::TIME_W-1:0]    quo_q;
	logic [wrm_pkg::WIN_W+1:0]     trial;
	logic                          fits;

	assign trial = {1'b0, rem_q, quo_q[wrm_pkg::TIME_W-1]} - {2'b00, div_q};
	assign fits  = ~trial[wrm_pkg::WIN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == wrm_pkg::STEP_W'(wrm_pkg::TIME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + wrm_pkg::STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= trial[wrm_pkg::WIN_W-1:0];
			end else begin
				rem_q <= {rem_q[wrm_pkg::WIN_W-2:0], quo_q[wrm_pkg::TIME_W-1]};
			end
			quo_q <= {quo_q[wrm_pkg::TIME_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

FILE: design/windowed_event_rate_meter.sv
// ----------------------------------------------------------------------------
// windowed_event_rate_meter: fixed window event counter
// Counts timestamped events in windows of window_ms and reports closed
// windows as (count, repeat) results.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries events: tdata = event time in ms, tlast = final event.
//   m_* carries results: tdata = count and repeat, tlast = final result
//   of the event that caused it.
//   cfg_* writes window_ms (0 acts as 1); write only while idle.
// Sequencing:
//   The first event of a stream is taken without leaving idle and gives no result.
//   Every later event holds s_tready low while the sequencer forms the
//   time difference (ST_SUB), runs the bit-serial divider (ST_DIV, one
//   quotient bit per cycle over the 48-bit difference), updates the
//   window (ST_CLOSE), then steps through one state per result slot
//   (ST_E1 to ST_E3); no new event is taken until it is back in idle.
//   An event earlier than the window start skips the divider.
//   Results pass through a single output register; a stalled m_tready
//   holds the sequencer at the next result, while the last one may wait
//   in the register as the next event is taken.
// Reset:
//   arst_n clears the window state and sets window_ms to 500.
// ----------------------------------------------------------------------------
module windowed_event_rate_meter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [47:0] event_time_ms
	input  logic        s_tlast,   // is_last_event
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] window_count, [63:32] window_repeat
	output logic        m_tlast,   // last_result
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // window_ms
);

	localparam int TW = wrm_pkg::TIME_W;
	localparam int CW = wrm_pkg::CNT_W;
	localparam int WW = wrm_pkg::WIN_W;

	wrm_pkg::state_t state_q, state_d;

	logic [WW-1:0] win_q;
	logic          started_q;
	logic [TW-1:0] ws_q;
	logic [CW-1:0] cnt_q;
	logic [TW-1:0] t_q;
	logic          last_q;
	logic [TW-1:0] d_q;
	logic          back_q;
	logic          do1_q, do2_q, do3_q;
	logic [CW-1:0] e_cnt_q;
	logic [CW-1:0] f_cnt_q;
	logic [CW-1:0] rep_q;
	logic          ovalid_q;
	logic [CW-1:0] ocnt_q;
	logic [CW-1:0] orep_q;
	logic          olast_q;

	logic [TW:0]   diff;
	logic          div_start;
	logic [WW-1:0] divisor;
	logic          div_done;
	logic [TW-1:0] quot;
	logic [WW-1:0] rem;

	logic          close;
	logic          multi;
	logic          beyond;
	logic [TW-1:0] qm1;
	logic [CW-1:0] cnt_base;
	logic [CW-1:0] cnt_new;
	logic          out_free;
	logic          accept;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !ovalid_q || m_tready;
	assign diff      = {1'b0, t_q} - {1'b0, ws_q};
	assign divisor   = (win_q == '0) ? WW'(1) : win_q;
	assign div_start = (state_q == wrm_pkg::ST_SUB) && !diff[TW];

	wrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff[TW-1:0]),
		.divisor  (divisor),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	assign close    = !back_q && (quot != '0);
	assign multi    = !back_q && (quot[TW-1:1] != '0);
	assign beyond   = !back_q && (close ? (rem != '0) : (d_q != '0));
	assign qm1      = quot - TW'(1);
	assign cnt_base = close ? '0 : cnt_q;
	assign cnt_new  = (!last_q || beyond) ? wrm_pkg::sat_inc(cnt_base) : cnt_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wrm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wrm_pkg::ST_IDLE: begin
				if (accept && started_q) state_d = wrm_pkg::ST_SUB;
			end
			wrm_pkg::ST_SUB: begin
				state_d = diff[TW] ? wrm_pkg::ST_CLOSE : wrm_pkg::ST_DIV;
			end
			wrm_pkg::ST_DIV: begin
				if (div_done) state_d = wrm_pkg::ST_CLOSE;
			end
			wrm_pkg::ST_CLOSE: begin
				state_d = wrm_pkg::ST_E1;
			end
			wrm_pkg::ST_E1: begin
				if (!do1_q || out_free) state_d = wrm_pkg::ST_E2;
			end
			wrm_pkg::ST_E2: begin
				if (!do2_q || out_free) state_d = wrm_pkg::ST_E3;
			end
			wrm_pkg::ST_E3: begin
				if (!do3_q || out_free) state_d = wrm_pkg::ST_IDLE;
			end
			default: state_d = wrm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= wrm_pkg::WIN_RESET;
			started_q <= 1'b0;
			ws_q      <= '0;
			cnt_q     <= '0;
		end else begin
			if (cfg_valid) win_q <= cfg_data;
			if (accept && !started_q) begin
				started_q <= !s_tlast;
				ws_q      <= s_tlast ? '0 : s_tdata;
				cnt_q     <= s_tlast ? '0 : CW'(1);
			end
			if (state_q == wrm_pkg::ST_CLOSE) begin
				if (last_q) begin
					started_q <= 1'b0;
					ws_q      <= '0;
					cnt_q     <= '0;
				end else begin
					if (close) ws_q <= t_q - TW'(rem);
					cnt_q <= cnt_new;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			t_q    <= s_tdata;
			last_q <= s_tlast;
		end
		if (state_q == wrm_pkg::ST_SUB) begin
			d_q    <= diff[TW-1:0];
			back_q <= diff[TW];
		end
		if (state_q == wrm_pkg::ST_CLOSE) begin
			do1_q   <= close;
			do2_q   <= multi;
			do3_q   <= last_q && beyond;
			e_cnt_q <= cnt_q;
			f_cnt_q <= cnt_new;
			rep_q   <= (qm1[TW-1:CW] != '0) ? wrm_pkg::CNT_MAX : qm1[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_free) begin
			ovalid_q <= ((state_q == wrm_pkg::ST_E1) && do1_q)
				|| ((state_q == wrm_pkg::ST_E2) && do2_q)
				|| ((state_q == wrm_pkg::ST_E3) && do3_q);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			case (state_q)
				wrm_pkg::ST_E1: begin
					ocnt_q  <= e_cnt_q;
					orep_q  <= CW'(1);
					olast_q <= !do2_q && !do3_q;
				end
				wrm_pkg::ST_E2: begin
					ocnt_q  <= e_cnt_q;
					orep_q  <= rep_q;
					olast_q <= !do3_q;
				end
				wrm_pkg::ST_E3: begin
					ocnt_q  <= f_cnt_q;
					orep_q  <= CW'(1);
					olast_q <= 1'b1;
				end
				default: begin
					ocnt_q  <= ocnt_q;
					orep_q  <= orep_q;
					olast_q <= olast_q;
				end
			endcase
		end
	end

	assign s_tready  = (state_q == wrm_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = ovalid_q;
	assign m_tdata   = {orep_q, ocnt_q};
	assign m_tlast   = olast_q;

endmodule

FILE: test/windowed_event_rate_meter_tb.sv
// ----------------------------------------------------------------------------
// windowed_event_rate_meter_tb: self-checking bench for the window counter
// Sends timestamped event streams with random gaps and checks every
// (count, repeat) result against an in-bench window predictor.
// ----------------------------------------------------------------------------
module windowed_event_rate_meter_tb;

	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int STALL_LIMIT  = 5000;

	typedef struct packed {
		logic [wrm_pkg::CNT_W-1:0] count;
		logic [wrm_pkg::CNT_W-1:0] reps;
		logic                      is_final;
	} window_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [wrm_pkg::TIME_W-1:0] s_tdata;   // [47:0] event_time_ms
	logic                       s_tlast;   // is_last_event
	logic                       m_tvalid;
	logic                       m_tready;
	logic [63:0]                m_tdata;   // [31:0] window_count, [63:32] window_repeat
	logic                       m_tlast;   // last_result
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [wrm_pkg::WIN_W-1:0]  cfg_data;  // window_ms

	window_result_t             expected_windows[$];
	logic [wrm_pkg::WIN_W-1:0]  win_len     = wrm_pkg::WIN_RESET;
	bit                         stream_open = 1'b0;
	logic [wrm_pkg::TIME_W-1:0] win_start   = '0;
	logic [wrm_pkg::CNT_W-1:0]  open_cnt    = '0;

	int  mismatches  = 0;
	int  stall_count = 0;
	bit  gaps_on     = 1'b1;
	logic rx_hold;
	event hold_start;

	windowed_event_rate_meter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [wrm_pkg::TIME_W-1:0] rand_time();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [63:0] eff_window();
		return (win_len == '0) ? 64'd1 : 64'(win_len);
	endfunction

	function automatic void push_window(input logic [wrm_pkg::CNT_W-1:0] cnt,
					    input logic [wrm_pkg::CNT_W-1:0] reps);
		window_result_t r;
		r.count    = cnt;
		r.reps     = reps;
		r.is_final = 1'b0;
		expected_windows.insert(expected_windows.size(), r);
	endfunction

	// close elapsed windows, count the event, flush on the final event
	function automatic void count_event(input logic [wrm_pkg::TIME_W-1:0] t,
					    input bit lst);
		logic [wrm_pkg::TIME_W-1:0] w;
		logic [wrm_pkg::TIME_W-1:0] k;
		int n;
		n = 0;
		w = wrm_pkg::TIME_W'(eff_window());
		if (!stream_open) begin
			stream_open = 1'b1;
			win_start   = t;
			open_cnt    = wrm_pkg::CNT_W'(1);
		end else begin
			if (t >= win_start && t - win_start >= w) begin
				k = (t - win_start) / w;
				push_window(open_cnt, wrm_pkg::CNT_W'(1));
				n++;
				if (k > 1) begin
					push_window(open_cnt, (k - 1 > wrm_pkg::CNT_MAX) ? wrm_pkg::CNT_MAX
						: wrm_pkg::CNT_W'(k - 1));
					n++;
				end
				win_start = win_start + k * w;
				open_cnt  = '0;
			end
			if (!lst || t > win_start)
				open_cnt = (open_cnt == wrm_pkg::CNT_MAX) ? open_cnt
					: open_cnt + wrm_pkg::CNT_W'(1);
		end
		if (lst) begin
			if (t > win_start) begin
				push_window(open_cnt, wrm_pkg::CNT_W'(1));
				n++;
			end
			stream_open = 1'b0;
			win_start   = '0;
			open_cnt    = '0;
		end
		if (n > 0)
			expected_windows[expected_windows.size() - 1].is_final = 1'b1;
	endfunction

	function automatic logic [wrm_pkg::TIME_W-1:0] next_time(
			input logic [wrm_pkg::TIME_W-1:0] cur);
		logic [63:0] w;
		int unsigned r;
		w = eff_window();
		r = $urandom_range(0, 99);
		if (r < 35)
			return cur + wrm_pkg::TIME_W'($urandom_range(0, 32'(w - 1)));
		else if (r < 50)
			return cur;
		else if (r < 65)
			return cur + wrm_pkg::TIME_W'(w * $urandom_range(1, 3));
		else if (r < 85)
			return cur + wrm_pkg::TIME_W'($urandom_range(32'(w), 32'(5 * w)));
		else if (r < 95)
			return cur + wrm_pkg::TIME_W'($urandom);
		return cur - wrm_pkg::TIME_W'($urandom_range(1, 32'(w)));
	endfunction

	// next window boundary at or after cur, so a final event lands on a window start
	function automatic logic [wrm_pkg::TIME_W-1:0] boundary_time(
			input logic [wrm_pkg::TIME_W-1:0] cur);
		logic [63:0] w;
		logic [63:0] span;
		if (!stream_open)
			return cur;
		if (cur <= win_start)
			return win_start;
		w    = eff_window();
		span = 64'(cur - win_start);
		return win_start + wrm_pkg::TIME_W'(((span + w - 1) / w) * w);
	endfunction

	task automatic flag_mismatch(input string field, input logic [63:0] got,
				     input logic [63:0] want);
		$display("mismatch on %s: got %0d, expected %0d", field, got, want);
		mismatches++;
	endtask

	task automatic send_event(input logic [wrm_pkg::TIME_W-1:0] t, input bit lst);
		int gap;
		gap = gaps_on ? idle_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= t;
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		count_event(t, lst);
	endtask

	task automatic write_window(input logic [wrm_pkg::WIN_W-1:0] v);
		s_tvalid <= 1'b0;
		while (expected_windows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		win_len = v;
	endtask

	task automatic test_default_window();
		gaps_on = 1'b1;
		send_event(48'd0, 1'b1);
		send_event(48'd1000, 1'b0);
		send_event(48'd1000, 1'b0);
		send_event(48'd1499, 1'b0);
		send_event(48'd1500, 1'b0);
		send_event(48'd3000, 1'b0);
		send_event(48'd3000, 1'b1);
		send_event(48'd5000, 1'b0);
		send_event(48'd4000, 1'b0);
		send_event(48'd4000, 1'b1);
		send_event(48'd10, 1'b0);
		send_event(48'd20, 1'b0);
		send_event(48'd700, 1'b1);
		send_event(48'd0, 1'b0);
		send_event({wrm_pkg::TIME_W{1'b1}}, 1'b1);
	endtask

	task automatic test_window_extremes();
		gaps_on = 1'b0;
		write_window('0);
		send_event(48'd5, 1'b0);
		send_event(48'd5, 1'b0);
		send_event(48'd6, 1'b0);
		send_event(48'd9, 1'b1);
		write_window({wrm_pkg::WIN_W{1'b1}});
		send_event(48'h8000_0000_0000, 1'b0);
		send_event(48'h8000_0000_fffe, 1'b0);
		send_event(48'h8000_0001_fffe, 1'b0);
		send_event(48'h8000_0004_0000, 1'b1);
		write_window(16'd1);
		send_event(48'd0, 1'b0);
		send_event({wrm_pkg::TIME_W{1'b1}}, 1'b0);
		send_event({wrm_pkg::TIME_W{1'b1}}, 1'b1);
	endtask

	task automatic test_output_backpressure();
		logic [wrm_pkg::TIME_W-1:0] t;
		write_window(16'd3);
		gaps_on = 1'b0;
		-> hold_start;
		t = 48'd100;
		send_event(t, 1'b0);
		repeat (12) begin
			t = t + 48'd20;
			send_event(t, 1'b0);
		end
		send_event(t + 48'd1, 1'b1);
	endtask

	task automatic test_random_streams(input int target);
		int sent;
		int len;
		int i;
		int unsigned r;
		bit fresh;
		bit noise;
		bit lst;
		logic [wrm_pkg::TIME_W-1:0] t;
		sent = 0;
		t    = '0;
		while (sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				write_window(16'd1);
			else if (r < 12)
				write_window({wrm_pkg::WIN_W{1'b1}});
			else if (r < 15)
				write_window('0);
			else
				write_window(wrm_pkg::WIN_W'($urandom_range(2, 1200)));
			gaps_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(3, 6)) begin
				len   = $urandom_range(1, 14);
				noise = ($urandom_range(0, 19) == 0);
				fresh = !stream_open;
				if (fresh)
					t = ($urandom_range(0, 3) == 0) ? rand_time()
						: wrm_pkg::TIME_W'($urandom_range(0, 1000000));
				for (i = 0; i < len; i++) begin
					lst = (i == len - 1) && ($urandom_range(0, 6) != 0);
					if (noise) begin
						t   = rand_time();
						lst = 1'($urandom_range(0, 1));
					end else if (!fresh) begin
						t = (lst && $urandom_range(0, 4) == 0) ? boundary_time(t)
							: next_time(t);
					end
					fresh = 1'b0;
					send_event(t, lst);
					sent++;
				end
			end
		end
	endtask

	initial begin
		rx_hold <= 1'b0;
		forever begin
			@(hold_start);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	initial begin
		int wait_n;
		wait_n = 0;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				m_tready <= 1'b0;
			end else if (wait_n > 0) begin
				m_tready <= 1'b0;
				wait_n--;
			end else begin
				m_tready <= 1'b1;
				if (gaps_on && $urandom_range(0, 3) == 0)
					wait_n = idle_len();
			end
		end
	end

	always @(posedge clk) begin : check_window
		window_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_windows.size() == 0) begin
				flag_mismatch("unexpected result count", 64'(m_tdata[31:0]), 64'd0);
			end else begin
				want = expected_windows.pop_front();
				if (m_tdata[31:0] !== want.count)
					flag_mismatch("window_count", 64'(m_tdata[31:0]), 64'(want.count));
				if (m_tdata[63:32] !== want.reps)
					flag_mismatch("window_repeat", 64'(m_tdata[63:32]), 64'(want.reps));
				if (m_tlast !== want.is_final)
					flag_mismatch("last_result", 64'(m_tlast), 64'(want.is_final));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stall_count = 0;
			else
				stall_count++;
			if (stall_count >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_default_window();
		test_window_extremes();
		test_output_backpressure();
		test_random_streams(355);
		s_tvalid <= 1'b0;
		while (expected_windows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
